// ----- hdl/pfa_pkg.sv -----
// Package for the pressure frame to altitude block.
// Holds widths, reset values, status codes and fixed-point constants.
// Depends on nothing.
package pfa_pkg;
  localparam int CHAR_W = 8;
  localparam int REF_W = 20;
  localparam int SCALE_W = 21;
  localparam int LAUNCH_W = 21;
  localparam int ALT_W = 25;
  localparam int STATUS_W = 2;
  localparam int POS_W = 6;
  localparam int ACC_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 21;
  localparam int LOG_W = 33;
  localparam int FRAC_BITS = 28;
  localparam int DIGITS_IN_WINDOW = 6;
  localparam int FRAME_LENGTH_DEF = 9;
  localparam int FIRST_DIGIT_POSITION_DEF = 2;
  localparam logic [POS_W-1:0] POS_MAX = 6'd63;
  localparam logic [ACC_W-1:0] ACC_MAX = 20'd999999;
  localparam logic [REF_W-1:0] REF_RESET = 20'd101325;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 21'd843179;
  localparam logic [LAUNCH_W-1:0] LAUNCH_RESET = 21'd0;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic signed [ALT_W-1:0] ALT_MIN = -25'sd2000000;
  localparam logic signed [ALT_W-1:0] ALT_MAX = 25'sd10000000;
  localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CFG_IDX_W-1:0] CFG_REF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FORMAT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOPRES = 2'd2;

  typedef enum logic [1:0] {JOB_COMPUTE, JOB_FORMAT, JOB_NOPRES, JOB_NOREF} job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    logic [ACC_W-1:0] pressure;
  } job_t;
endpackage

// ----- hdl/pfa_if.sv -----
// Valid/ready channel interfaces for the input characters and the results.
// Depends on pfa_pkg.
interface pfa_in_if;
  logic valid;
  logic ready;
  logic [pfa_pkg::CHAR_W-1:0] frame_char;
  logic frame_last;
  modport source(output valid, frame_char, frame_last, input ready);
  modport sink(input valid, frame_char, frame_last, output ready);
endinterface

interface pfa_out_if;
  logic valid;
  logic ready;
  logic signed [pfa_pkg::ALT_W-1:0] altitude_cm;
  logic [pfa_pkg::STATUS_W-1:0] status;
  modport source(output valid, altitude_cm, status, input ready);
  modport sink(input valid, altitude_cm, status, output ready);
endinterface

// ----- hdl/pfa_front.sv -----
// Front end: parses characters, builds the pressure and classifies frames.
// Depends on pfa_pkg.
module pfa_front #(
  parameter int FRAME_LENGTH = pfa_pkg::FRAME_LENGTH_DEF,
  parameter int FIRST_DIGIT_POSITION = pfa_pkg::FIRST_DIGIT_POSITION_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [pfa_pkg::CHAR_W-1:0] in_frame_char,
  input  logic in_frame_last,
  input  logic [pfa_pkg::REF_W-1:0] ref_pa,
  output logic job_valid,
  input  logic job_ready,
  output pfa_pkg::job_t job
);
  localparam int PW = pfa_pkg::POS_W;
  localparam logic [PW-1:0] FIRST = PW'(FIRST_DIGIT_POSITION);
  localparam logic [PW-1:0] WEND = PW'(FIRST_DIGIT_POSITION + pfa_pkg::DIGITS_IN_WINDOW);
  localparam logic [PW-1:0] LASTPOS = PW'(FRAME_LENGTH - 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [pfa_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic seen_r, seen_nxt;
  logic accept, is_digit;
  logic [pfa_pkg::ACC_W+3:0] prod;

  assign in_ready = job_ready;
  assign accept = in_valid && in_ready;
  assign is_digit = (pos_r >= FIRST) && (pos_r < WEND) && (pos_r < LASTPOS) &&
                    (in_frame_char >= pfa_pkg::CH_ZERO) && (in_frame_char <= pfa_pkg::CH_NINE);
  assign prod = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                {20'd0, in_frame_char[3:0]};

  always_comb begin
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    seen_nxt = seen_r;
    job.pressure = acc_r;
    job.kind = pfa_pkg::JOB_COMPUTE;
    if (accept) begin
      if (is_digit) begin
        acc_nxt = (prod > {4'd0, pfa_pkg::ACC_MAX}) ? pfa_pkg::ACC_MAX :
                  prod[pfa_pkg::ACC_W-1:0];
        seen_nxt = 1'b1;
      end
      if (pos_r != pfa_pkg::POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (in_frame_last) begin
        pos_nxt = '0;
        acc_nxt = '0;
        seen_nxt = 1'b0;
      end
    end
    if (pos_r != LASTPOS || in_frame_char != pfa_pkg::CH_SEMI) begin
      job.kind = pfa_pkg::JOB_FORMAT;
    end else if (!seen_r || acc_r == '0) begin
      job.kind = pfa_pkg::JOB_NOPRES;
    end else if (ref_pa == '0) begin
      job.kind = pfa_pkg::JOB_NOREF;
    end
  end

  assign job_valid = in_valid && in_frame_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
      seen_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      seen_r <= seen_nxt;
    end
  end
endmodule

// ----- hdl/pfa_queue.sv -----
// Two-entry queue of classified frame jobs between front and back end.
// Depends on pfa_pkg.
module pfa_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  pfa_pkg::job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output pfa_pkg::job_t rd_job
);
  pfa_pkg::job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ----- hdl/pfa_back.sv -----
// Back end: iterative log2 by repeated squaring, scaling and saturation.
// Depends on pfa_pkg.
module pfa_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  pfa_pkg::job_t job,
  input  logic [pfa_pkg::REF_W-1:0] ref_pa,
  input  logic [pfa_pkg::SCALE_W-1:0] scale_cm,
  input  logic [pfa_pkg::LAUNCH_W-1:0] launch_cm,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [pfa_pkg::ALT_W-1:0] out_altitude_cm,
  output logic [pfa_pkg::STATUS_W-1:0] out_status
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQA = 4'd1;
  localparam logic [3:0] S_SQB = 4'd2;
  localparam logic [3:0] S_SQC = 4'd3;
  localparam logic [3:0] S_SQD = 4'd4;
  localparam logic [3:0] S_SQE = 4'd5;
  localparam logic [3:0] S_LN = 4'd6;
  localparam logic [3:0] S_TRM = 4'd7;
  localparam logic [3:0] S_ALT = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam int ALTX = 52;

  logic [3:0] st_r;
  logic [4:0] it_r;
  logic sel_r;
  logic [31:0] y_r;
  logic [27:0] frac_r;
  logic [4:0] e_r;
  logic [pfa_pkg::LOG_W-1:0] lp_r;
  logic [pfa_pkg::LOG_W-1:0] mag_r;
  logic below_r;
  logic [63:0] pp0_r, pp1_r;
  logic [63:0] sq;
  logic [31:0] ysh;
  logic [63:0] ln_r;
  logic [48:0] tp_r;
  logic signed [ALTX-1:0] alt_c;

  logic [pfa_pkg::REF_W-1:0] x_sel;
  logic [4:0] e_c;
  logic [pfa_pkg::LOG_W-1:0] lr_c;

  assign x_sel = (st_r == S_SQD) ? ref_pa : job.pressure;
  always_comb begin
    e_c = '0;
    for (int i = 1; i < 20; i++) begin
      if (x_sel[i]) e_c = 5'(i);
    end
  end

  assign sq = pp0_r + (pp1_r << 16);
  assign ysh = sq[61:30];
  assign lr_c = {e_r, frac_r};
  assign job_ready = (st_r == S_OUT) && out_ready;
  assign out_valid = (st_r == S_OUT);

  logic signed [ALTX-1:0] launch_x;
  assign launch_x = ALTX'(signed'(launch_cm));
  assign alt_c = below_r ? launch_x + signed'({3'b0, tp_r}) :
                           launch_x - signed'({3'b0, tp_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            unique case (job.kind)
              pfa_pkg::JOB_COMPUTE: begin
                st_r <= S_SQA;
                sel_r <= 1'b0;
                e_r <= e_c;
                y_r <= 32'({job.pressure, 30'd0} >> e_c);
                frac_r <= '0;
                it_r <= '0;
              end
              pfa_pkg::JOB_FORMAT: begin
                out_altitude_cm <= '0;
                out_status <= pfa_pkg::ST_FORMAT;
                st_r <= S_OUT;
              end
              pfa_pkg::JOB_NOPRES: begin
                out_altitude_cm <= pfa_pkg::ALT_MAX;
                out_status <= pfa_pkg::ST_NOPRES;
                st_r <= S_OUT;
              end
              default: begin
                out_altitude_cm <= pfa_pkg::ALT_MIN;
                out_status <= pfa_pkg::ST_NOPRES;
                st_r <= S_OUT;
              end
            endcase
          end
        end
        S_SQA: begin
          pp0_r <= 64'(y_r * y_r[15:0]);
          pp1_r <= 64'(y_r * y_r[31:16]);
          st_r <= S_SQB;
        end
        S_SQB: begin
          frac_r <= {frac_r[26:0], ysh[31]};
          y_r <= ysh[31] ? {1'b0, ysh[31:1]} : ysh;
          it_r <= it_r + 5'd1;
          if (it_r == 5'd27) begin
            st_r <= S_SQC;
          end else begin
            st_r <= S_SQA;
          end
        end
        S_SQC: begin
          if (!sel_r) begin
            lp_r <= lr_c;
            sel_r <= 1'b1;
            st_r <= S_SQD;
          end else begin
            below_r <= lp_r < lr_c;
            mag_r <= (lp_r < lr_c) ? lr_c - lp_r : lp_r - lr_c;
            st_r <= S_SQE;
          end
        end
        S_SQD: begin
          e_r <= e_c;
          y_r <= 32'({ref_pa, 30'd0} >> e_c);
          frac_r <= '0;
          it_r <= '0;
          st_r <= S_SQA;
        end
        S_SQE: begin
          pp0_r <= 64'(mag_r[15:0] * pfa_pkg::LN2_Q30);
          pp1_r <= 64'(mag_r[32:16] * pfa_pkg::LN2_Q30);
          st_r <= S_LN;
        end
        S_LN: begin
          ln_r <= (pp0_r + (pp1_r << 16) + 64'd536870912) >> 30;
          st_r <= S_TRM;
        end
        S_TRM: begin
          tp_r <= 49'(((64'(scale_cm) * ln_r[35:0]) + 64'd134217728) >> 28);
          st_r <= S_ALT;
        end
        S_ALT: begin
          if (alt_c < ALTX'(pfa_pkg::ALT_MIN)) out_altitude_cm <= pfa_pkg::ALT_MIN;
          else if (alt_c > ALTX'(pfa_pkg::ALT_MAX)) out_altitude_cm <= pfa_pkg::ALT_MAX;
          else out_altitude_cm <= alt_c[pfa_pkg::ALT_W-1:0];
          out_status <= pfa_pkg::ST_OK;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/pressure_frame_to_altitude.sv -----
// Top level of the barometric altitude block.
// A valid frame's result is computed after its last character by 56 squaring steps of
// the shared log2 unit, followed by the control and scaling states; error frames go
// straight to the result without using the log2 unit.
// Characters are taken one per cycle while the two-entry job queue has room.
// Synchronous active-low reset restores register defaults and clears frame state.
module pressure_frame_to_altitude #(
  parameter int FRAME_LENGTH = pfa_pkg::FRAME_LENGTH_DEF,
  parameter int FIRST_DIGIT_POSITION = pfa_pkg::FIRST_DIGIT_POSITION_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pfa_in_if.sink in_ch,
  pfa_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  logic [pfa_pkg::REF_W-1:0] ref_r;
  logic [pfa_pkg::SCALE_W-1:0] scale_r;
  logic [pfa_pkg::LAUNCH_W-1:0] launch_r;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  pfa_pkg::job_t fj, bj;
  logic fin_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= pfa_pkg::REF_RESET;
      scale_r <= pfa_pkg::SCALE_RESET;
      launch_r <= pfa_pkg::LAUNCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfa_pkg::CFG_REF: ref_r <= cfg_data[pfa_pkg::REF_W-1:0];
        pfa_pkg::CFG_SCALE: scale_r <= cfg_data;
        pfa_pkg::CFG_LAUNCH: launch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pfa_front #(.FRAME_LENGTH(FRAME_LENGTH), .FIRST_DIGIT_POSITION(FIRST_DIGIT_POSITION)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(fin_ready),
    .in_frame_char(in_ch.frame_char), .in_frame_last(in_ch.frame_last), .ref_pa(ref_r),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));
  assign in_ch.ready = fin_ready;

  pfa_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj));

  pfa_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .ref_pa(ref_r), .scale_cm(scale_r), .launch_cm(launch_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_altitude_cm(out_ch.altitude_cm), .out_status(out_ch.status));
endmodule

// ----- hdl/pfa_checker.sv -----
// Port-level checker for the altitude block, bound to the top level.
// Depends on pfa_pkg and the channel interfaces.
module pfa_props (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [pfa_pkg::STATUS_W-1:0] out_status,
  input logic signed [pfa_pkg::ALT_W-1:0] out_altitude_cm
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");
  a_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pfa_pkg::ST_FORMAT |-> out_altitude_cm == '0)
    else $error("format error with nonzero altitude");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("unknown status");
  a_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_altitude_cm >= pfa_pkg::ALT_MIN && out_altitude_cm <= pfa_pkg::ALT_MAX)
    else $error("altitude out of range");
endmodule

bind pressure_frame_to_altitude pfa_props u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_altitude_cm(out_ch.altitude_cm));
